### src/mandelbrot_escape_time_quad_macros.svh
// Assertion helpers for the escape-time block.
// Both expect clk and rst_n in scope.
`ifndef MANDELBROT_ESCAPE_TIME_QUAD_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_QUAD_MACROS_SVH

// Same-cycle implication.
`define MBQ_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MBQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mbq_pkg.sv
package mbq_pkg;

    localparam int LANES         = 4;
    localparam int COORD_BITS    = 32;
    localparam int FRAC_BITS     = 23;
    localparam int COUNT_BITS    = 16;
    localparam int SHADE_BITS    = 8;
    localparam int IDX_BITS      = 12;
    localparam int STEP_BITS     = 31;
    localparam int ESC_BITS      = 8;
    // col + lane offset, one bit of headroom past the last column
    localparam int LANE_IDX_BITS = IDX_BITS + 1;
    // |z| components below 16.0 fit this signed width
    localparam int SMALL_BITS    = FRAC_BITS + 5;
    localparam int PROD_BITS     = 2 * SMALL_BITS;
    localparam int DIFF_BITS     = PROD_BITS + 1;
    localparam int WIDE_BITS     = 48;

    localparam int APB_DATA_BITS = 32;
    localparam int ADDR_BITS     = 5;
    localparam int REG_SEL_BITS  = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;
    typedef logic [COUNT_BITS-1:0]        count_t;
    typedef logic [SHADE_BITS-1:0]        shade_t;
    typedef logic [IDX_BITS-1:0]          idx_t;
    typedef logic [STEP_BITS-1:0]         step_t;
    typedef logic [ESC_BITS-1:0]          esc_t;
    typedef logic [REG_SEL_BITS-1:0]      reg_sel_t;

    typedef struct packed {
        count_t max_iter;
        esc_t   escape_sq;
    } iter_cfg_t;

    localparam reg_sel_t REG_ORIGIN_RE = 3'd0;
    localparam reg_sel_t REG_ORIGIN_IM = 3'd1;
    localparam reg_sel_t REG_STEP_RE   = 3'd2;
    localparam reg_sel_t REG_STEP_IM   = 3'd3;
    localparam reg_sel_t REG_MAX_ITER  = 3'd4;
    localparam reg_sel_t REG_ESCAPE_SQ = 3'd5;

    localparam coord_t RST_ORIGIN  = -32'sd16777216;
    localparam step_t  RST_STEP    = 31'd32768;
    localparam count_t RST_MAX     = 16'd256;
    localparam esc_t   RST_ESCAPE  = 8'd100;

    localparam shade_t SHADE_WHITE = 8'd255;
    localparam shade_t SHADE_BLACK = 8'd0;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Clamp a wide signed value into the coordinate range.
    function automatic coord_t sat_coord(input wide_t v);
        logic [WIDE_BITS-COORD_BITS:0] hi;
        coord_t res;
        hi = v[WIDE_BITS-1:COORD_BITS-1];
        if (hi == '0 || hi == '1)
        begin
            res = v[COORD_BITS-1:0];
        end
        else if (v[WIDE_BITS-1])
        begin
            res = COORD_MIN;
        end
        else
        begin
            res = COORD_MAX;
        end
        return res;
    endfunction

endpackage

### src/mbq_chan_if.sv
interface mbq_in_if;
    logic          valid;
    logic          ready;
    mbq_pkg::idx_t group_col;
    mbq_pkg::idx_t row_index;

    modport source (output valid, group_col, row_index, input ready);
    modport sink   (input valid, group_col, row_index, output ready);
endinterface

interface mbq_out_if;
    logic            valid;
    logic            ready;
    mbq_pkg::count_t count_0;
    mbq_pkg::count_t count_1;
    mbq_pkg::count_t count_2;
    mbq_pkg::count_t count_3;
    mbq_pkg::shade_t shade_0;
    mbq_pkg::shade_t shade_1;
    mbq_pkg::shade_t shade_2;
    mbq_pkg::shade_t shade_3;

    modport source (output valid, count_0, count_1, count_2, count_3,
                    shade_0, shade_1, shade_2, shade_3, input ready);
    modport sink   (input valid, count_0, count_1, count_2, count_3,
                    shade_0, shade_1, shade_2, shade_3, output ready);
endinterface

### src/mbq_coord.sv
module mbq_coord (
    input  logic            clk,
    input  logic            load,
    input  mbq_pkg::idx_t   group_col,
    input  mbq_pkg::idx_t   row_index,
    input  mbq_pkg::coord_t origin_re,
    input  mbq_pkg::coord_t origin_im,
    input  mbq_pkg::step_t  step_re,
    input  mbq_pkg::step_t  step_im,
    output mbq_pkg::coord_t cre [mbq_pkg::LANES],
    output mbq_pkg::coord_t cim
);

    localparam int RE_PROD_BITS = mbq_pkg::LANE_IDX_BITS + mbq_pkg::STEP_BITS;
    localparam int IM_PROD_BITS = mbq_pkg::IDX_BITS + mbq_pkg::STEP_BITS;

    mbq_pkg::coord_t cre_reg [mbq_pkg::LANES];
    mbq_pkg::coord_t cim_reg;

    logic [IM_PROD_BITS-1:0] im_prod;
    mbq_pkg::wide_t          im_sum;

    assign im_prod = IM_PROD_BITS'(row_index) * IM_PROD_BITS'(step_im);
    assign im_sum  = mbq_pkg::WIDE_BITS'(origin_im)
                   + $signed(mbq_pkg::WIDE_BITS'(im_prod));

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < mbq_pkg::LANES; i++)
            begin
                cre_reg[i] <= mbq_pkg::sat_coord(
                    mbq_pkg::WIDE_BITS'(origin_re)
                  + $signed(mbq_pkg::WIDE_BITS'(
                        RE_PROD_BITS'(mbq_pkg::LANE_IDX_BITS'(group_col)
                                      + mbq_pkg::LANE_IDX_BITS'(i))
                      * RE_PROD_BITS'(step_re))));
            end
            cim_reg <= mbq_pkg::sat_coord(im_sum);
        end
    end

    assign cre = cre_reg;
    assign cim = cim_reg;

endmodule

### src/mbq_lane.sv
module mbq_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mbq_pkg::coord_t    cre,
    input  mbq_pkg::coord_t    cim,
    input  mbq_pkg::iter_cfg_t cfg,
    output logic               busy,
    output mbq_pkg::count_t    count
);

    localparam int SB = mbq_pkg::SMALL_BITS;
    localparam int CB = mbq_pkg::COORD_BITS;
    localparam int PB = mbq_pkg::PROD_BITS;
    localparam int DB = mbq_pkg::DIFF_BITS;
    localparam int FB = mbq_pkg::FRAC_BITS;

    logic            busy_reg;
    logic            busy_next;
    mbq_pkg::coord_t x_reg;
    mbq_pkg::coord_t y_reg;
    mbq_pkg::count_t cnt_reg;

    logic [CB-SB:0]        x_hi;
    logic [CB-SB:0]        y_hi;
    logic                  x_big;
    logic                  y_big;
    logic signed [SB-1:0]  xs;
    logic signed [SB-1:0]  ys;
    logic signed [PB-1:0]  x2;
    logic signed [PB-1:0]  y2;
    logic signed [PB-1:0]  xy;
    logic [PB-1:0]         mag_sq;
    logic [PB-1:0]         limit;
    logic signed [DB-1:0]  diff;
    mbq_pkg::wide_t        re_sum;
    mbq_pkg::wide_t        im_sum;
    logic                  stop;

    // |v| >= 16.0 escapes; the most negative small value counts as 16.0 too
    assign x_hi  = x_reg[CB-1:SB-1];
    assign y_hi  = y_reg[CB-1:SB-1];
    assign x_big = !(x_hi == '0 || x_hi == '1) || (x_hi == '1 && x_reg[SB-2:0] == '0);
    assign y_big = !(y_hi == '0 || y_hi == '1) || (y_hi == '1 && y_reg[SB-2:0] == '0);

    assign xs = x_reg[SB-1:0];
    assign ys = y_reg[SB-1:0];
    assign x2 = PB'(xs) * PB'(xs);
    assign y2 = PB'(ys) * PB'(ys);
    assign xy = PB'(xs) * PB'(ys);

    assign mag_sq = $unsigned(x2) + $unsigned(y2);
    assign limit  = PB'({cfg.escape_sq, {(2*FB){1'b0}}});

    // floor shifts back to Q.23, then add c
    assign diff   = DB'(x2) - DB'(y2);
    assign re_sum = mbq_pkg::WIDE_BITS'($signed(diff[DB-1:FB])) + mbq_pkg::WIDE_BITS'(cre);
    assign im_sum = mbq_pkg::WIDE_BITS'($signed(xy[PB-1:FB-1])) + mbq_pkg::WIDE_BITS'(cim);

    assign stop = (cnt_reg >= cfg.max_iter) || x_big || y_big || (mag_sq >= limit);

    always_comb
    begin
        busy_next = busy_reg && !stop;
        if (start)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= cre;
            y_reg   <= cim;
            cnt_reg <= '0;
        end
        else if (busy_reg && !stop)
        begin
            x_reg   <= mbq_pkg::sat_coord(re_sum);
            y_reg   <= mbq_pkg::sat_coord(im_sum);
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign busy  = busy_reg;
    assign count = cnt_reg;

endmodule

### src/mbq_merge.sv
module mbq_merge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  mbq_pkg::count_t   counts [mbq_pkg::LANES],
    input  mbq_pkg::count_t   max_iter,
    output logic              slot_free,
    mbq_out_if.source         out_ch
);

    logic            valid_reg;
    logic            valid_next;
    mbq_pkg::count_t count_reg [mbq_pkg::LANES];
    mbq_pkg::shade_t shade_reg [mbq_pkg::LANES];

    function automatic mbq_pkg::shade_t grey(input mbq_pkg::count_t n,
                                             input mbq_pkg::count_t lim);
        mbq_pkg::shade_t s;
        if (n == lim || n[0])
        begin
            s = mbq_pkg::SHADE_BLACK;
        end
        else
        begin
            s = mbq_pkg::SHADE_WHITE;
        end
        return s;
    endfunction

    assign slot_free = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < mbq_pkg::LANES; i++)
            begin
                count_reg[i] <= counts[i];
                shade_reg[i] <= grey(counts[i], max_iter);
            end
        end
    end

    assign out_ch.valid   = valid_reg;
    assign out_ch.count_0 = count_reg[0];
    assign out_ch.count_1 = count_reg[1];
    assign out_ch.count_2 = count_reg[2];
    assign out_ch.count_3 = count_reg[3];
    assign out_ch.shade_0 = shade_reg[0];
    assign out_ch.shade_1 = shade_reg[1];
    assign out_ch.shade_2 = shade_reg[2];
    assign out_ch.shade_3 = shade_reg[3];

endmodule

### src/mandelbrot_escape_time_quad.sv
// One group is in flight at a time, and the slowest lane sets the pace;
//   each lane runs one z = z^2 + c update per cycle.
// The output register holds a finished beat while the next group is taken in.
// Reset (rst_n, asynchronous, active low): control idle, registers to their documented values.
`include "mandelbrot_escape_time_quad_macros.svh"

module mandelbrot_escape_time_quad (
    input  logic                                clk,
    input  logic                                rst_n,
    mbq_in_if.sink                              in_ch,
    mbq_out_if.source                           out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mbq_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [mbq_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [mbq_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);

    // Sequencer: take a beat, compute c for all lanes, then let lanes iterate.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Configuration registers
    mbq_pkg::coord_t origin_re_reg;
    mbq_pkg::coord_t origin_im_reg;
    mbq_pkg::step_t  step_re_reg;
    mbq_pkg::step_t  step_im_reg;
    mbq_pkg::count_t max_iter_reg;
    mbq_pkg::esc_t   escape_sq_reg;

    logic              cfg_wr;
    mbq_pkg::reg_sel_t reg_sel;

    logic                     in_fire;
    logic                     lane_start;
    logic                     merge_load;
    logic                     slot_free;
    logic [mbq_pkg::LANES-1:0] lane_busy;
    mbq_pkg::iter_cfg_t       iter_cfg;
    mbq_pkg::coord_t          cre [mbq_pkg::LANES];
    mbq_pkg::coord_t          cim;
    mbq_pkg::count_t          counts [mbq_pkg::LANES];

    //------------------------------------------------------------------
    // APB register file. pready is tied high: every access completes
    // in its access phase. Reads return the register zero-extended
    // (origins are already full width).
    //------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = paddr[mbq_pkg::ADDR_BITS-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_re_reg <= mbq_pkg::RST_ORIGIN;
            origin_im_reg <= mbq_pkg::RST_ORIGIN;
            step_re_reg   <= mbq_pkg::RST_STEP;
            step_im_reg   <= mbq_pkg::RST_STEP;
            max_iter_reg  <= mbq_pkg::RST_MAX;
            escape_sq_reg <= mbq_pkg::RST_ESCAPE;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                mbq_pkg::REG_ORIGIN_RE: origin_re_reg <= pwdata;
                mbq_pkg::REG_ORIGIN_IM: origin_im_reg <= pwdata;
                mbq_pkg::REG_STEP_RE:   step_re_reg   <= pwdata[mbq_pkg::STEP_BITS-1:0];
                mbq_pkg::REG_STEP_IM:   step_im_reg   <= pwdata[mbq_pkg::STEP_BITS-1:0];
                mbq_pkg::REG_MAX_ITER:  max_iter_reg  <= pwdata[mbq_pkg::COUNT_BITS-1:0];
                mbq_pkg::REG_ESCAPE_SQ: escape_sq_reg <= pwdata[mbq_pkg::ESC_BITS-1:0];
                default: ;  // unmapped addresses: drop the write
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            mbq_pkg::REG_ORIGIN_RE: prdata = origin_re_reg;
            mbq_pkg::REG_ORIGIN_IM: prdata = origin_im_reg;
            mbq_pkg::REG_STEP_RE:   prdata = mbq_pkg::APB_DATA_BITS'(step_re_reg);
            mbq_pkg::REG_STEP_IM:   prdata = mbq_pkg::APB_DATA_BITS'(step_im_reg);
            mbq_pkg::REG_MAX_ITER:  prdata = mbq_pkg::APB_DATA_BITS'(max_iter_reg);
            mbq_pkg::REG_ESCAPE_SQ: prdata = mbq_pkg::APB_DATA_BITS'(escape_sq_reg);
            default:                prdata = '0;
        endcase
    end

    assign iter_cfg.max_iter  = max_iter_reg;
    assign iter_cfg.escape_sq = escape_sq_reg;

    //------------------------------------------------------------------
    // Sequencer
    //   IDLE: accept a beat; the coordinate stage captures c on that edge.
    //   LOAD: c is registered; start every lane from z = c.
    //   RUN : wait until all lanes have frozen and the output register is
    //         free, then load the result and go back to IDLE. The result
    //         may still sit in the output register while the next beat
    //         is accepted.
    //------------------------------------------------------------------
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        lane_start = 1'b0;
        merge_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                lane_start = 1'b1;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (lane_busy == '0 && slot_free)
                begin
                    merge_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    //------------------------------------------------------------------
    // Datapath: per-lane c, the lanes themselves, and the merge/output
    // register that turns counts into shades.
    //------------------------------------------------------------------
    mbq_coord u_coord (
        .clk       (clk),
        .load      (in_fire),
        .group_col (in_ch.group_col),
        .row_index (in_ch.row_index),
        .origin_re (origin_re_reg),
        .origin_im (origin_im_reg),
        .step_re   (step_re_reg),
        .step_im   (step_im_reg),
        .cre       (cre),
        .cim       (cim)
    );

    for (genvar g = 0; g < mbq_pkg::LANES; g++)
    begin : g_lane
        mbq_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .start (lane_start),
            .cre   (cre[g]),
            .cim   (cim),
            .cfg   (iter_cfg),
            .busy  (lane_busy[g]),
            .count (counts[g])
        );
    end

    mbq_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (merge_load),
        .counts    (counts),
        .max_iter  (max_iter_reg),
        .slot_free (slot_free),
        .out_ch    (out_ch)
    );

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    `MBQ_ASSERT_NEXT(a_accept_loads, in_fire, state_reg == S_LOAD,
        "accepted beat did not move the sequencer to LOAD")
    `MBQ_ASSERT_NEXT(a_all_lanes_start, state_reg == S_LOAD, lane_busy == '1,
        "not every lane started after LOAD")
    `MBQ_ASSERT_IMP(a_busy_only_in_run, lane_busy != '0, state_reg == S_RUN,
        "lane busy outside RUN")
    `MBQ_ASSERT_NEXT(a_load_shows_valid, merge_load, out_ch.valid,
        "result load did not raise output valid")

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int HALF_PERIOD      = 10;
    localparam int RESET_CYCLES     = 12;
    localparam int MAX_GAP          = 10;
    // Output hold-off long enough for the block to fill and stall its input.
    localparam int STALL_CYCLES     = 3000;
    // The slowest legal group runs 65535 updates; allow that several times over.
    localparam int QUIET_LIMIT      = 300000;
    localparam int SETTLE_CYCLES    = 300;
    localparam int MAX_REPORTS      = 10;
    localparam int RAND_PHASES      = 7;
    localparam int GROUPS_PER_PHASE = 200;
    localparam int N_PROBES         = 22;

    // Random phases with a special role.
    localparam int PHASE_STOCK = 0;
    localparam int PHASE_BURST = 2;
    localparam int PHASE_STALL = 3;
    localparam int PHASE_PAUSE = 4;
    localparam int PHASE_NOISE = 6;

    localparam longint COORD_TOP  = (longint'(1) <<< (mbq_pkg::COORD_BITS - 1)) - 1;
    localparam longint COORD_BOT  = -(longint'(1) <<< (mbq_pkg::COORD_BITS - 1));
    // Any component at 16.0 or beyond counts as escaped.
    localparam longint ESCAPE_BOX = longint'(1) <<< (mbq_pkg::FRAC_BITS + 4);

    localparam mbq_pkg::reg_sel_t REG_ORDER [0:5] = '{
        mbq_pkg::REG_ORIGIN_RE, mbq_pkg::REG_ORIGIN_IM, mbq_pkg::REG_STEP_RE,
        mbq_pkg::REG_STEP_IM, mbq_pkg::REG_MAX_ITER, mbq_pkg::REG_ESCAPE_SQ};

    typedef struct packed {
        mbq_pkg::coord_t origin_re;
        mbq_pkg::coord_t origin_im;
        mbq_pkg::step_t  step_re;
        mbq_pkg::step_t  step_im;
        mbq_pkg::count_t max_iter;
        mbq_pkg::esc_t   escape_sq;
    } view_cfg_t;

    typedef struct packed {
        mbq_pkg::idx_t                          col;
        mbq_pkg::idx_t                          row;
        mbq_pkg::count_t [mbq_pkg::LANES-1:0]   cnt;
        mbq_pkg::shade_t [mbq_pkg::LANES-1:0]   shd;
    } group_result_t;

    // Register settings used by the directed probes.
    typedef enum logic [2:0] {
        SET_STOCK,      // values after reset
        SET_DEEP,       // largest iteration limit
        SET_ZERO_MAX,   // iteration limit of zero
        SET_ZERO_ESC,   // escape threshold of zero
        SET_HUGE,       // saturating origins and steps
        SET_ORIGIN,     // every pixel at c = 0, limit of one
        SET_TIP_OUT,    // c = -2 with threshold exactly |c|^2
        SET_TIP_IN      // c = -2 with threshold just above, fixed point at 2
    } probe_set_t;

    typedef struct packed {
        probe_set_t      set;
        mbq_pkg::idx_t   col;
        mbq_pkg::idx_t   row;
        logic            known;  // expected value typed in below, same for all lanes
        mbq_pkg::count_t cnt;
        mbq_pkg::shade_t shd;
    } probe_t;

    localparam probe_t PROBES [0:N_PROBES-1] = '{
        '{SET_STOCK,    12'd4095, 12'd4095, 1'b1, 16'd0,   mbq_pkg::SHADE_WHITE},
        '{SET_STOCK,    12'd0,    12'd4095, 1'b1, 16'd0,   mbq_pkg::SHADE_WHITE},
        '{SET_STOCK,    12'd4095, 12'd0,    1'b1, 16'd0,   mbq_pkg::SHADE_WHITE},
        '{SET_STOCK,    12'd512,  12'd512,  1'b0, 16'd0,   mbq_pkg::SHADE_BLACK},
        '{SET_STOCK,    12'd0,    12'd0,    1'b0, 16'd0,   mbq_pkg::SHADE_BLACK},
        '{SET_STOCK,    12'd300,  12'd600,  1'b0, 16'd0,   mbq_pkg::SHADE_BLACK},
        '{SET_STOCK,    12'd448,  12'd512,  1'b0, 16'd0,   mbq_pkg::SHADE_BLACK},
        '{SET_STOCK,    12'd640,  12'd700,  1'b0, 16'd0,   mbq_pkg::SHADE_BLACK},
        '{SET_DEEP,     12'd512,  12'd512,  1'b0, 16'd0,   mbq_pkg::SHADE_BLACK},
        '{SET_DEEP,     12'd4095, 12'd4095, 1'b1, 16'd0,   mbq_pkg::SHADE_WHITE},
        '{SET_ZERO_MAX, 12'd512,  12'd512,  1'b1, 16'd0,   mbq_pkg::SHADE_BLACK},
        '{SET_ZERO_MAX, 12'd4095, 12'd4095, 1'b1, 16'd0,   mbq_pkg::SHADE_BLACK},
        '{SET_ZERO_ESC, 12'd0,    12'd0,    1'b1, 16'd0,   mbq_pkg::SHADE_WHITE},
        '{SET_ZERO_ESC, 12'd512,  12'd512,  1'b1, 16'd0,   mbq_pkg::SHADE_WHITE},
        '{SET_HUGE,     12'd0,    12'd0,    1'b1, 16'd0,   mbq_pkg::SHADE_WHITE},
        '{SET_HUGE,     12'd4095, 12'd4095, 1'b1, 16'd0,   mbq_pkg::SHADE_WHITE},
        '{SET_HUGE,     12'd1,    12'd7,    1'b1, 16'd0,   mbq_pkg::SHADE_WHITE},
        '{SET_ORIGIN,   12'd0,    12'd0,    1'b1, 16'd1,   mbq_pkg::SHADE_BLACK},
        '{SET_ORIGIN,   12'd4095, 12'd4095, 1'b1, 16'd1,   mbq_pkg::SHADE_BLACK},
        '{SET_TIP_OUT,  12'd100,  12'd200,  1'b1, 16'd0,   mbq_pkg::SHADE_WHITE},
        '{SET_TIP_IN,   12'd100,  12'd200,  1'b1, 16'd256, mbq_pkg::SHADE_BLACK},
        '{SET_TIP_IN,   12'd4095, 12'd4095, 1'b1, 16'd256, mbq_pkg::SHADE_BLACK}
    };

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [mbq_pkg::ADDR_BITS-1:0]      paddr;
    logic [mbq_pkg::APB_DATA_BITS-1:0]  pwdata;
    logic [mbq_pkg::APB_DATA_BITS-1:0]  prdata;
    logic                               pready;

    mbq_in_if  in_ch ();
    mbq_out_if out_ch ();

    mandelbrot_escape_time_quad i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Mirror of the register file, updated whenever a new setting is applied.
    view_cfg_t     view;
    view_cfg_t     probe_views [0:7];
    // Pixel groups accepted by the block whose results have not come back yet.
    group_result_t pending_groups [$];

    int failures       = 0;
    int results_seen   = 0;
    int random_groups  = 0;
    int settings_count = 0;
    int quiet_cycles   = 0;
    bit no_idle        = 1'b0;
    bit hold_request   = 1'b0;

    task automatic note_failure(input string what);
        failures++;
        if (failures <= MAX_REPORTS)
        begin
            $display("ERROR: %s", what);
        end
    endtask

    // ------------------------------------------------------------------
    // Escape-time predictor
    // ------------------------------------------------------------------

    // Clamp to the signed coordinate range.
    function automatic longint clamp_coord(input longint v);
        if (v > COORD_TOP)
        begin
            return COORD_TOP;
        end
        if (v < COORD_BOT)
        begin
            return COORD_BOT;
        end
        return v;
    endfunction

    // Run one lane: iterate z = z^2 + c from z = c, counting while |z|^2 stays
    // under the threshold. Products keep 46 fraction bits; each update drops
    // back to 23 by flooring, adds c and saturates.
    function automatic mbq_pkg::count_t escape_count(input longint cre, input longint cim);
        longint      x;
        longint      y;
        longint      x2;
        longint      y2;
        longint      xy;
        longint      bound;
        int unsigned n;
        x     = cre;
        y     = cim;
        n     = 0;
        bound = longint'(view.escape_sq) <<< (2 * mbq_pkg::FRAC_BITS);
        while (n < int'(view.max_iter))
        begin
            // Stop before squaring anything big: the threshold is below 256.
            if ((x < 0 ? -x : x) >= ESCAPE_BOX || (y < 0 ? -y : y) >= ESCAPE_BOX)
            begin
                break;
            end
            x2 = x * x;
            y2 = y * y;
            xy = x * y;
            if (x2 + y2 >= bound)
            begin
                break;
            end
            n++;
            x = clamp_coord(((x2 - y2) >>> mbq_pkg::FRAC_BITS) + cre);
            y = clamp_coord(((2 * xy) >>> mbq_pkg::FRAC_BITS) + cim);
        end
        return mbq_pkg::count_t'(n);
    endfunction

    // Work out counts and shades of the four pixels col..col+3 on one row.
    // Columns past the last one are not wrapped.
    function automatic group_result_t predict_group(input mbq_pkg::idx_t col,
                                                    input mbq_pkg::idx_t row);
        group_result_t   res;
        longint          cre;
        longint          cim;
        mbq_pkg::count_t n;
        res.col = col;
        res.row = row;
        cim = clamp_coord(longint'($signed(view.origin_im))
                          + longint'(row) * longint'(view.step_im));
        for (int lane = 0; lane < mbq_pkg::LANES; lane++)
        begin
            cre = clamp_coord(longint'($signed(view.origin_re))
                              + longint'(int'(col) + lane) * longint'(view.step_re));
            n = escape_count(cre, cim);
            res.cnt[lane] = n;
            // Black inside the set, otherwise alternate by parity.
            res.shd[lane] = (n == view.max_iter || n[0]) ? mbq_pkg::SHADE_BLACK
                                                         : mbq_pkg::SHADE_WHITE;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------

    function automatic logic [mbq_pkg::APB_DATA_BITS-1:0] reg_image(
        input view_cfg_t v, input mbq_pkg::reg_sel_t sel);
        logic [mbq_pkg::APB_DATA_BITS-1:0] img;
        case (sel)
            mbq_pkg::REG_ORIGIN_RE: img = v.origin_re;
            mbq_pkg::REG_ORIGIN_IM: img = v.origin_im;
            mbq_pkg::REG_STEP_RE:   img = mbq_pkg::APB_DATA_BITS'(v.step_re);
            mbq_pkg::REG_STEP_IM:   img = mbq_pkg::APB_DATA_BITS'(v.step_im);
            mbq_pkg::REG_MAX_ITER:  img = mbq_pkg::APB_DATA_BITS'(v.max_iter);
            mbq_pkg::REG_ESCAPE_SQ: img = mbq_pkg::APB_DATA_BITS'(v.escape_sq);
            default:                img = '0;
        endcase
        return img;
    endfunction

    // Setup phase, access phase, then psel and penable drop before the task returns, so that the next transfer
    // never touches psel in the same step.
    task automatic reg_write(input mbq_pkg::reg_sel_t sel,
                             input logic [mbq_pkg::APB_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_read(input mbq_pkg::reg_sel_t sel,
                            output logic [mbq_pkg::APB_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Read every register back and compare with the mirror.
    task automatic check_regs();
        logic [mbq_pkg::APB_DATA_BITS-1:0] got;
        foreach (REG_ORDER[i])
        begin
            reg_read(REG_ORDER[i], got);
            if (got !== reg_image(view, REG_ORDER[i]))
            begin
                note_failure($sformatf("register %0d reads %h, expected %h",
                                       REG_ORDER[i], got, reg_image(view, REG_ORDER[i])));
            end
        end
    endtask

    // Write all six registers; only call with the block idle.
    task automatic apply_view(input view_cfg_t v);
        foreach (REG_ORDER[i])
        begin
            reg_write(REG_ORDER[i], reg_image(v, REG_ORDER[i]));
        end
        view = v;
        settings_count++;
        check_regs();
    endtask

    function automatic view_cfg_t make_view(input mbq_pkg::coord_t ore,
                                            input mbq_pkg::coord_t oim,
                                            input mbq_pkg::step_t sre,
                                            input mbq_pkg::step_t sim,
                                            input mbq_pkg::count_t mx,
                                            input mbq_pkg::esc_t esc);
        view_cfg_t v;
        v.origin_re = ore;
        v.origin_im = oim;
        v.step_re   = sre;
        v.step_im   = sim;
        v.max_iter  = mx;
        v.escape_sq = esc;
        return v;
    endfunction

    // Random window over the interesting part of the plane, or pure noise.
    function automatic view_cfg_t random_view(input int phase);
        view_cfg_t v;
        if (phase == PHASE_NOISE)
        begin
            v.origin_re = mbq_pkg::coord_t'($urandom);
            v.origin_im = mbq_pkg::coord_t'($urandom);
            v.step_re   = mbq_pkg::step_t'($urandom);
            v.step_im   = mbq_pkg::step_t'($urandom);
            v.max_iter  = mbq_pkg::count_t'($urandom_range(0, 64));
            v.escape_sq = mbq_pkg::esc_t'($urandom_range(0, 255));
        end
        else
        begin
            // Left edge -1.5 .. -2.5, top edge -1.0 .. -1.75.
            v.origin_re = -mbq_pkg::coord_t'($urandom_range(12582912, 20971520));
            v.origin_im = -mbq_pkg::coord_t'($urandom_range(8388608, 14680064));
            v.step_re   = mbq_pkg::step_t'($urandom_range(2048, 12288));
            v.step_im   = mbq_pkg::step_t'($urandom_range(2048, 12288));
            v.max_iter  = (phase == PHASE_STOCK) ? mbq_pkg::RST_MAX
                                                 : mbq_pkg::count_t'($urandom_range(1, 96));
            v.escape_sq = $urandom_range(0, 1) ? mbq_pkg::esc_t'(4)
                                               : mbq_pkg::esc_t'($urandom_range(1, 255));
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one group after a gap; record its expectation once accepted.
    // Drop valid only when a gap follows, so it never toggles within a step.
    task automatic send_group(input mbq_pkg::idx_t col, input mbq_pkg::idx_t row,
                              input int gap, input group_result_t want);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.group_col <= col;
        in_ch.row_index <= row;
        do @(posedge clk); while (!in_ch.ready);
        pending_groups.push_back(want);
    endtask

    // Drop valid and wait until every outstanding result is back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_groups.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure, one long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin
        int            gap;
        group_result_t got;
        group_result_t want;
        logic          bad;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap = STALL_CYCLES;
            end
            else
            begin
                gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            results_seen++;
            got.col = '0;
            got.row = '0;
            got.cnt = {out_ch.count_3, out_ch.count_2, out_ch.count_1, out_ch.count_0};
            got.shd = {out_ch.shade_3, out_ch.shade_2, out_ch.shade_1, out_ch.shade_0};
            if (pending_groups.size() == 0)
            begin
                note_failure($sformatf("beat with nothing outstanding: counts %h shades %h",
                                       got.cnt, got.shd));
            end
            else
            begin
                want = pending_groups.pop_front();
                bad = 1'b0;
                for (int lane = 0; lane < mbq_pkg::LANES; lane++)
                begin
                    if (got.cnt[lane] !== want.cnt[lane] || got.shd[lane] !== want.shd[lane])
                    begin
                        bad = 1'b1;
                    end
                end
                if (bad)
                begin
                    note_failure($sformatf({"group col %0d row %0d: expected counts %h ",
                                            "shades %h, got counts %h shades %h"},
                                           want.col, want.row, want.cnt, want.shd,
                                           got.cnt, got.shd));
                end
            end
        end
    end

    // Watchdog: end the run after too long without any beat on either channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_groups.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        probe_t        pr;
        probe_set_t    active_set;
        mbq_pkg::idx_t col;
        mbq_pkg::idx_t row;
        group_result_t want;

        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.group_col <= '0;
        in_ch.row_index <= '0;

        probe_views[SET_STOCK]    = make_view(mbq_pkg::RST_ORIGIN, mbq_pkg::RST_ORIGIN,
                                              mbq_pkg::RST_STEP, mbq_pkg::RST_STEP,
                                              mbq_pkg::RST_MAX, mbq_pkg::RST_ESCAPE);
        probe_views[SET_DEEP]     = make_view(mbq_pkg::RST_ORIGIN, mbq_pkg::RST_ORIGIN,
                                              mbq_pkg::RST_STEP, mbq_pkg::RST_STEP,
                                              16'hFFFF, mbq_pkg::RST_ESCAPE);
        probe_views[SET_ZERO_MAX] = make_view(mbq_pkg::RST_ORIGIN, mbq_pkg::RST_ORIGIN,
                                              mbq_pkg::RST_STEP, mbq_pkg::RST_STEP,
                                              16'd0, 8'd255);
        probe_views[SET_ZERO_ESC] = make_view(mbq_pkg::RST_ORIGIN, mbq_pkg::RST_ORIGIN,
                                              mbq_pkg::RST_STEP, mbq_pkg::RST_STEP,
                                              mbq_pkg::RST_MAX, 8'd0);
        probe_views[SET_HUGE]     = make_view(mbq_pkg::COORD_MAX, mbq_pkg::COORD_MIN,
                                              '1, '0, 16'hFFFF, 8'd255);
        probe_views[SET_ORIGIN]   = make_view('0, '0, '0, '0, 16'd1, 8'd255);
        probe_views[SET_TIP_OUT]  = make_view(mbq_pkg::RST_ORIGIN, '0, '0, '0,
                                              mbq_pkg::RST_MAX, 8'd4);
        probe_views[SET_TIP_IN]   = make_view(mbq_pkg::RST_ORIGIN, '0, '0, '0,
                                              mbq_pkg::RST_MAX, 8'd5);

        // Hold reset, then release it on a clock edge.
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The register file must come up with its documented values.
        view = probe_views[SET_STOCK];
        check_regs();

        // Directed probes: switch settings only with the block drained.
        active_set = SET_STOCK;
        for (int i = 0; i < N_PROBES; i++)
        begin
            pr = PROBES[i];
            if (pr.set != active_set)
            begin
                drain();
                apply_view(probe_views[pr.set]);
                active_set = pr.set;
            end
            if (pr.known)
            begin
                want.col = pr.col;
                want.row = pr.row;
                want.cnt = {mbq_pkg::LANES{pr.cnt}};
                want.shd = {mbq_pkg::LANES{pr.shd}};
            end
            else
            begin
                want = predict_group(pr.col, pr.row);
            end
            send_group(pr.col, pr.row, $urandom_range(0, MAX_GAP), want);
        end

        // Random phases, each under a fresh register setting.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            drain();
            apply_view(random_view(p));
            // One phase runs back to back on both sides.
            no_idle = (p == PHASE_BURST);
            // Stall the output long enough for the input to back up.
            if (p == PHASE_STALL)
            begin
                hold_request = 1'b1;
            end
            for (int k = 0; k < GROUPS_PER_PHASE; k++)
            begin
                // Pause the sender halfway until the block is empty.
                if (p == PHASE_PAUSE && k == GROUPS_PER_PHASE / 2)
                begin
                    drain();
                end
                col = mbq_pkg::idx_t'($urandom_range(0, 4095));
                row = mbq_pkg::idx_t'($urandom_range(0, 4095));
                send_group(col, row, no_idle ? 0 : $urandom_range(0, MAX_GAP),
                           predict_group(col, row));
                random_groups++;
            end
        end
        no_idle = 1'b0;

        // Wait for the last results, then watch a while for stray beats.
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_groups.size() != 0)
        begin
            note_failure($sformatf("%0d results never arrived", pending_groups.size()));
        end

        $display("Ran %0d directed and %0d random pixel groups under %0d register settings;",
                 N_PROBES, random_groups, settings_count);
        $display("compared %0d results, with zero limits, saturation, a full stall and a pause.",
                 results_seen);
        if (failures == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d failures", failures);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
